FILE: rtl/core/frlp_pkg.sv
// ----------------------------------------------------------------------------
// frlp_pkg
// Shared types and codes for the flash ring log pointer manager.
// ----------------------------------------------------------------------------
package frlp_pkg;

    // request type codes on req_type
    localparam logic [1:0] REQ_APPEND = 2'd0;
    localparam logic [1:0] REQ_READ   = 2'd1;
    localparam logic [1:0] REQ_CLEAR  = 2'd2;

    // depth of the request queue between front and back
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        CMD_ERASE = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_READ  = 2'd2,
        CMD_DONE  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        KIND_APPEND,
        KIND_READ,
        KIND_CLEAR,
        KIND_NONE
    } req_kind_t;

    typedef struct packed {
        req_kind_t   kind;
        logic [9:0]  offset;
        logic [4:0]  burst;
    } req_entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ERASE_HEAD,
        ST_ERASE_AHEAD,
        ST_WRITE,
        ST_READ_SETUP,
        ST_READ,
        ST_CLEAR,
        ST_DONE
    } back_state_t;

endpackage

FILE: rtl/core/frlp_front.sv
// ----------------------------------------------------------------------------
// frlp_front
// Takes request words, classifies them and clamps the read burst length.
// ----------------------------------------------------------------------------
module frlp_front #(
    parameter int READ_BURST_MAX = 16
) (
    input  logic                 start,
    input  logic [1:0]           req_type,
    input  logic [9:0]           read_offset,
    input  logic [4:0]           read_max,
    input  logic                 full,
    output logic                 push,
    output frlp_pkg::req_entry_t entry
);
    import frlp_pkg::*;

    assign push = start && !full;

    always_comb
    begin
        entry.offset = read_offset;
        if (int'(read_max) > READ_BURST_MAX)
            entry.burst = 5'(READ_BURST_MAX);
        else
            entry.burst = read_max;
        unique case (req_type)
            REQ_APPEND: entry.kind = KIND_APPEND;
            REQ_READ:   entry.kind = KIND_READ;
            REQ_CLEAR:  entry.kind = KIND_CLEAR;
            default:    entry.kind = KIND_NONE;
        endcase
    end

endmodule

FILE: rtl/core/frlp_queue.sv
// ----------------------------------------------------------------------------
// frlp_queue
// Short request queue that decouples the front from the command sequencer.
// ----------------------------------------------------------------------------
module frlp_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  frlp_pkg::req_entry_t push_entry,
    input  logic                 pop,
    output logic                 full,
    output logic                 valid,
    output frlp_pkg::req_entry_t head_entry
);
    import frlp_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    req_entry_t         entries_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;

    assign full       = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign valid      = (count_reg != '0);
    assign head_entry = entries_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entries_reg[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count above depth");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("push into full queue");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> valid)
        else $error("pop from empty queue");

endmodule

FILE: rtl/core/frlp_back.sv
// ----------------------------------------------------------------------------
// frlp_back
// Command sequencer: holds head/tail pointers and blank bits, issues one
// flash command word per cycle for each queued request.
// ----------------------------------------------------------------------------
module frlp_back #(
    parameter int SECTOR_COUNT     = 16,
    parameter int SLOTS_PER_SECTOR = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    input  frlp_pkg::req_entry_t q_entry,
    output logic                 q_pop,
    output logic                 strobe,
    output logic [1:0]           command,
    output logic [3:0]           sector_index,
    output logic [9:0]           slot_index,
    output logic [9:0]           record_count,
    output logic                 last
);
    import frlp_pkg::*;

    localparam int TOTAL  = SECTOR_COUNT * SLOTS_PER_SECTOR;
    localparam int SLOT_W = $clog2(TOTAL);
    localparam int SEC_W  = $clog2(SECTOR_COUNT);
    localparam int OFF_W  = (SLOTS_PER_SECTOR > 1) ? $clog2(SLOTS_PER_SECTOR) : 1;
    localparam int WIDE_W = ((SLOT_W > 10) ? SLOT_W : 10) + 1;

    back_state_t          state_reg, state_next;
    logic [SLOT_W-1:0]    head_lin_reg;
    logic [SEC_W-1:0]     head_sec_reg;
    logic [OFF_W-1:0]     head_off_reg;
    logic [SLOT_W-1:0]    tail_lin_reg;
    logic [SEC_W-1:0]     tail_sec_reg;
    logic [SECTOR_COUNT-1:0] blank_reg;
    logic [9:0]           off_reg;
    logic [4:0]           burst_reg;
    logic [SLOT_W-1:0]    rd_ptr_reg;
    logic [4:0]           rd_left_reg;
    logic [SEC_W-1:0]     clr_idx_reg;
    logic [SLOT_W-1:0]    count_reg;

    logic [SLOT_W-1:0]    held;
    logic [SEC_W-1:0]     ahead_sec;
    logic [SEC_W-1:0]     erase_sec;
    logic [SEC_W-1:0]     after_sec;
    logic [SLOT_W-1:0]    after_lin;
    logic                 tail_hit;
    logic [WIDE_W-1:0]    off_w;
    logic [WIDE_W-1:0]    cnt_w;
    logic [WIDE_W-1:0]    avail;
    logic [WIDE_W-1:0]    rd_sum;
    logic                 rd_none;
    logic [4:0]           rd_take;
    logic [SLOT_W-1:0]    rd_start;
    logic [SLOT_W-1:0]    rd_ptr_inc;

    // records held, modulo the ring size
    always_comb
    begin
        if (head_lin_reg >= tail_lin_reg)
            held = head_lin_reg - tail_lin_reg;
        else
            held = head_lin_reg - tail_lin_reg + SLOT_W'(TOTAL);
    end

    always_comb
    begin
        ahead_sec = (head_sec_reg == SEC_W'(SECTOR_COUNT - 1)) ? '0 : head_sec_reg + 1'b1;
        erase_sec = (state_reg == ST_ERASE_HEAD) ? head_sec_reg : ahead_sec;
        after_sec = (erase_sec == SEC_W'(SECTOR_COUNT - 1)) ? '0 : erase_sec + 1'b1;
        after_lin = SLOT_W'(int'(after_sec) * SLOTS_PER_SECTOR);
        // tail only moves when the erased sector holds the oldest record
        tail_hit  = (held != '0) && (tail_sec_reg == erase_sec);
    end

    always_comb
    begin
        off_w    = WIDE_W'(off_reg);
        cnt_w    = WIDE_W'(count_reg);
        avail    = cnt_w - off_w;
        rd_none  = (off_w >= cnt_w) || (burst_reg == '0);
        rd_take  = (avail < WIDE_W'(burst_reg)) ? 5'(avail) : burst_reg;
        // offset is below the count here, so one wrap is enough
        rd_sum   = WIDE_W'(tail_lin_reg) + off_w;
        if (rd_sum >= WIDE_W'(TOTAL))
            rd_start = SLOT_W'(rd_sum - WIDE_W'(TOTAL));
        else
            rd_start = SLOT_W'(rd_sum);
        rd_ptr_inc = (rd_ptr_reg == SLOT_W'(TOTAL - 1)) ? '0 : rd_ptr_reg + 1'b1;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    unique case (q_entry.kind)
                        KIND_APPEND:
                        begin
                            if (head_off_reg != '0)
                                state_next = ST_WRITE;
                            else if (blank_reg[head_sec_reg])
                                state_next = ST_ERASE_AHEAD;
                            else
                                state_next = ST_ERASE_HEAD;
                        end
                        KIND_READ:  state_next = ST_READ_SETUP;
                        KIND_CLEAR: state_next = ST_CLEAR;
                        default:    state_next = ST_DONE;
                    endcase
                end
            end
            ST_ERASE_HEAD:  state_next = ST_ERASE_AHEAD;
            ST_ERASE_AHEAD: state_next = ST_WRITE;
            ST_WRITE:       state_next = ST_DONE;
            ST_READ_SETUP:  state_next = rd_none ? ST_DONE : ST_READ;
            ST_READ:        state_next = (rd_left_reg == 5'd1) ? ST_DONE : ST_READ;
            ST_CLEAR:
            begin
                if (clr_idx_reg == SEC_W'(SECTOR_COUNT - 1))
                    state_next = ST_DONE;
            end
            ST_DONE:        state_next = ST_IDLE;
            default:        state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        q_pop        = 1'b0;
        strobe       = 1'b0;
        command      = CMD_DONE;
        sector_index = '0;
        slot_index   = '0;
        record_count = '0;
        last         = 1'b0;
        unique case (state_reg)
            ST_IDLE:
                q_pop = q_valid;
            ST_ERASE_HEAD, ST_ERASE_AHEAD:
            begin
                strobe       = 1'b1;
                command      = CMD_ERASE;
                sector_index = 4'(erase_sec);
            end
            ST_WRITE:
            begin
                strobe     = 1'b1;
                command    = CMD_WRITE;
                slot_index = 10'(head_lin_reg);
            end
            ST_READ:
            begin
                strobe     = 1'b1;
                command    = CMD_READ;
                slot_index = 10'(rd_ptr_reg);
            end
            ST_CLEAR:
            begin
                strobe       = 1'b1;
                command      = CMD_ERASE;
                sector_index = 4'(clr_idx_reg);
            end
            ST_DONE:
            begin
                strobe       = 1'b1;
                command      = CMD_DONE;
                record_count = 10'(held);
                last         = 1'b1;
            end
            default:
                q_pop = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            head_lin_reg <= '0;
            head_sec_reg <= '0;
            head_off_reg <= '0;
            tail_lin_reg <= '0;
            tail_sec_reg <= '0;
            blank_reg    <= '1;
            off_reg      <= '0;
            burst_reg    <= '0;
            rd_ptr_reg   <= '0;
            rd_left_reg  <= '0;
            clr_idx_reg  <= '0;
            count_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= held;
            unique case (state_reg)
                ST_IDLE:
                begin
                    off_reg     <= q_entry.offset;
                    burst_reg   <= q_entry.burst;
                    clr_idx_reg <= '0;
                end
                ST_ERASE_HEAD, ST_ERASE_AHEAD:
                begin
                    blank_reg[erase_sec] <= 1'b1;
                    if (tail_hit)
                    begin
                        tail_sec_reg <= after_sec;
                        tail_lin_reg <= after_lin;
                    end
                end
                ST_WRITE:
                begin
                    blank_reg[head_sec_reg] <= 1'b0;
                    head_lin_reg <= (head_lin_reg == SLOT_W'(TOTAL - 1)) ?
                                    '0 : head_lin_reg + 1'b1;
                    if (head_off_reg == OFF_W'(SLOTS_PER_SECTOR - 1))
                    begin
                        head_off_reg <= '0;
                        head_sec_reg <= ahead_sec;
                    end
                    else
                        head_off_reg <= head_off_reg + 1'b1;
                end
                ST_READ_SETUP:
                begin
                    rd_ptr_reg  <= rd_start;
                    rd_left_reg <= rd_take;
                end
                ST_READ:
                begin
                    rd_ptr_reg  <= rd_ptr_inc;
                    rd_left_reg <= rd_left_reg - 1'b1;
                end
                ST_CLEAR:
                begin
                    blank_reg[clr_idx_reg] <= 1'b1;
                    if (clr_idx_reg == SEC_W'(SECTOR_COUNT - 1))
                    begin
                        clr_idx_reg  <= '0;
                        head_lin_reg <= '0;
                        head_sec_reg <= '0;
                        head_off_reg <= '0;
                        tail_lin_reg <= '0;
                        tail_sec_reg <= '0;
                    end
                    else
                        clr_idx_reg <= clr_idx_reg + 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    a_gap_after_done: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && last) |=> !strobe)
        else $error("word issued right after done");

    a_head_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        head_lin_reg == SLOT_W'(int'(head_sec_reg) * SLOTS_PER_SECTOR + int'(head_off_reg)))
        else $error("head slot and head sector out of step");

    a_tail_on_boundary: assert property (@(posedge clk) disable iff (!rst_n)
        tail_lin_reg == SLOT_W'(int'(tail_sec_reg) * SLOTS_PER_SECTOR))
        else $error("tail slot not at start of its sector");

    a_read_left: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ) |-> (rd_left_reg != '0))
        else $error("read issued with nothing left");

endmodule

FILE: rtl/core/flash_ring_log_pointer_manager.sv
// ----------------------------------------------------------------------------
// flash_ring_log_pointer_manager
// Head/tail pointer keeper for a circular record log on sector-erased flash.
// ----------------------------------------------------------------------------
// A request word is taken on a rising edge with start high and busy low.
// req_type selects append, read range or clear; read_offset and read_max
// apply to reads only, read_max clipped to READ_BURST_MAX.
// Each request produces a run of command words on command, sector_index,
// slot_index, record_count and last, each valid for one cycle with strobe
// high; the receiver has no way to hold them off. The run always ends with a
// done word that carries the record count and has last set.
// A two-entry request queue sits between the decoder and the sequencer, so
// busy rises only when both entries wait. The sequencer issues one word per
// cycle within a run, after it fetches the request from the queue. An
// append at a sector start erases the head sector unless blank, then the
// sector ahead, before its write word; a read has a setup step and one read
// word per slot; a clear erases every sector; an unused code, done only.
// After reset the log is empty, both pointers are zero and every sector is
// marked blank; no clearing pass is needed.
// ----------------------------------------------------------------------------
module flash_ring_log_pointer_manager #(
    parameter int SECTOR_COUNT     = 16,
    parameter int SLOTS_PER_SECTOR = 64,
    parameter int READ_BURST_MAX   = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] req_type,
    input  logic [9:0] read_offset,
    input  logic [4:0] read_max,
    output logic       strobe,
    output logic [1:0] command,
    output logic [3:0] sector_index,
    output logic [9:0] slot_index,
    output logic [9:0] record_count,
    output logic       last
);
    import frlp_pkg::*;

    logic       push;
    logic       pop;
    logic       q_full;
    logic       q_valid;
    req_entry_t push_entry;
    req_entry_t head_entry;

    assign busy = q_full;

    frlp_front #(
        .READ_BURST_MAX (READ_BURST_MAX)
    ) u_front (
        .start       (start),
        .req_type    (req_type),
        .read_offset (read_offset),
        .read_max    (read_max),
        .full        (q_full),
        .push        (push),
        .entry       (push_entry)
    );

    frlp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .full       (q_full),
        .valid      (q_valid),
        .head_entry (head_entry)
    );

    frlp_back #(
        .SECTOR_COUNT     (SECTOR_COUNT),
        .SLOTS_PER_SECTOR (SLOTS_PER_SECTOR)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_entry      (head_entry),
        .q_pop        (pop),
        .strobe       (strobe),
        .command      (command),
        .sector_index (sector_index),
        .slot_index   (slot_index),
        .record_count (record_count),
        .last         (last)
    );

endmodule
